>>> rtl/scpt_pkg.sv
// Shared types, constants and rounding helpers for the stepper command
// position tracker. No dependencies; imported by every rtl module.
package scpt_pkg;

  // Frame framing words and limits
  localparam logic [15:0] HEAD_WORD  = 16'hFEEF;
  localparam logic [15:0] TAIL_WORD  = 16'hEEFF;
  localparam logic [3:0]  FRAME_MIN  = 4'd9;
  localparam logic [30:0] RESET_TURN = 31'd15000;
  localparam logic [48:0] TIMER_CLK  = 49'd84000000;

  // Special angle results
  localparam logic [31:0] ANGLE_NAN = 32'h7FC00000;
  localparam logic [31:0] ANGLE_INF = 32'h7F800000;

  // Function codes carried through the queue
  localparam logic [3:0] FN_ECHO   = 4'd0;
  localparam logic [3:0] FN_TURN   = 4'd1;
  localparam logic [3:0] FN_SPEED  = 4'd2;
  localparam logic [3:0] FN_ZERO   = 4'd3;
  localparam logic [3:0] FN_ANGLE  = 4'd4;
  localparam logic [3:0] FN_STATUS = 4'd5;
  localparam logic [3:0] FN_FWD    = 4'd6;
  localparam logic [3:0] FN_REV    = 4'd7;
  localparam logic [3:0] FN_STOP   = 4'd8;

  // Command queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Shared divider geometry
  localparam int DIV_NUM_W = 49;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  typedef enum logic [1:0] {
    DIR_STOP = 2'b00,
    DIR_FWD  = 2'b01,
    DIR_REV  = 2'b11
  } dir_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_BASE,
    ST_DIV_Q,
    ST_NORM_P,
    ST_MUL,
    ST_NORM_D,
    ST_DIV_F,
    ST_DONE
  } back_state_e;

  // Queue head seen by the back end
  typedef struct packed {
    logic        valid;
    logic        tick;
    logic [3:0]  fn;
    logic [31:0] payload;
  } q_head_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
    logic                 rem_nz;
  } div_rsp_t;

  typedef struct packed {
    logic        ovf;
    logic [23:0] m;
  } rnd_t;

  // Round-to-nearest-even of a 24-bit mantissa with guard and sticky
  function automatic rnd_t rne24(input logic [23:0] m, input logic g, input logic s);
    logic [24:0] sum;
    rnd_t        r;
    sum   = {1'b0, m} + {24'd0, (g & (s | m[0]))};
    r.ovf = sum[24];
    r.m   = sum[24] ? 24'h800000 : sum[23:0];
    return r;
  endfunction

  // Round a left-normalized 31-bit integer to a 24-bit mantissa
  function automatic rnd_t rnd_norm(input logic [30:0] x);
    return rne24(x[30:7], x[6], |x[5:0]);
  endfunction

endpackage

>>> rtl/scpt_front.sv
// Front end: validates and classifies input items, queues kept ones.
// Depends on scpt_pkg.
module scpt_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cmd_i,
  input  logic [3:0]            received_bytes_i,
  input  logic [15:0]           frame_head_i,
  input  logic [7:0]            function_code_i,
  input  logic [31:0]           payload_i,
  input  logic [15:0]           frame_tail_i,
  output scpt_pkg::q_head_t     head_o,
  input  logic                  pop_i
);
  import scpt_pkg::*;

  logic              tick_mem [QDEPTH];
  logic [3:0]        fn_mem   [QDEPTH];
  logic [31:0]       pay_mem  [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              full, keep, push, pop;

  // Ticks always count; frames need length, framing and a known function
  assign keep = (cmd_i == 1'b0) ||
                ((received_bytes_i >= FRAME_MIN) && (frame_head_i == HEAD_WORD) &&
                 (frame_tail_i == TAIL_WORD) && (function_code_i <= {4'd0, FN_STOP}));

  assign full       = (cnt_q == QCNT_W'(QDEPTH));
  assign in_stall_o = full;
  assign push       = in_valid_i && !full && keep;
  assign pop        = pop_i && (cnt_q != '0);

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      tick_mem[wr_ptr_q] <= ~cmd_i;
      fn_mem[wr_ptr_q]   <= function_code_i[3:0];
      pay_mem[wr_ptr_q]  <= payload_i;
    end
  end

  assign head_o.valid   = (cnt_q != '0);
  assign head_o.tick    = tick_mem[rd_ptr_q];
  assign head_o.fn      = fn_mem[rd_ptr_q];
  assign head_o.payload = pay_mem[rd_ptr_q];

endmodule

>>> rtl/scpt_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on scpt_pkg.
module scpt_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scpt_pkg::div_req_t req_i,
  output scpt_pkg::div_rsp_t rsp_o
);
  import scpt_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_NUM_W-1:0] num_q, quo_q;
  logic [DIV_DEN_W-1:0] den_q, rem_q;
  logic [DIV_DEN_W:0]   trial, diff;
  logic                 qbit;

  // One restoring step
  assign trial = {rem_q, num_q[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign qbit  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q <= qbit ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo_q <= {quo_q[DIV_NUM_W-2:0], qbit};
      num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
    end else if (req_i.start) begin
      num_q <= req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.quot   = quo_q;
  assign rsp_o.rem_nz = |rem_q;

endmodule

>>> rtl/scpt_back.sv
// Back end: executes queued ticks and commands, holds the tracker state,
// builds the float angle and the timer values. Depends on scpt_pkg.
module scpt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        prescaler_i,
  input  scpt_pkg::q_head_t  head_i,
  output logic               pop_o,
  output scpt_pkg::div_req_t div_req_o,
  input  scpt_pkg::div_rsp_t div_rsp_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         reply_function_o,
  output logic [31:0]        reply_payload_o,
  output logic               direction_level_o,
  output logic               pulses_running_o,
  output logic [31:0]        period_value_o,
  output logic [31:0]        compare_value_o
);
  import scpt_pkg::*;

  back_state_e state_q, state_d;

  // Architectural state
  logic [30:0] pos_q, ppt_q;
  dir_e        dir_q;
  logic        en_q, pin_q;
  logic [31:0] reload_q, compare_q;

  // Work registers
  logic [3:0]  fn_q;
  logic [31:0] rep_q, pay_q;
  logic [30:0] x_q;
  logic [4:0]  sh_q;
  logic [23:0] ms_q;
  logic [8:0]  es_q, ed_q;

  // Output register
  logic        out_valid_q;
  logic [3:0]  o_fn_q;
  logic [31:0] o_pay_q, o_per_q, o_cmp_q;
  logic        o_dir_q, o_run_q;

  logic        cmd_go, out_free;
  logic [32:0] tick_nxt;
  logic [30:0] tick_pos;
  rnd_t        nrm;
  logic [29:0] prod;
  rnd_t        mrnd;
  logic [8:0]  mexp;
  logic [25:0] fq;
  rnd_t        frnd;
  logic [8:0]  fexp;
  logic [31:0] q_spd;

  assign cmd_go   = (state_q == ST_IDLE) && head_i.valid && !head_i.tick;
  assign out_free = !out_valid_q || !out_stall_i;

  // Position step with both wraps
  always_comb begin
    tick_nxt = {2'b00, pos_q} + {{31{dir_q[1]}}, dir_q};
    if ($signed(tick_nxt) > $signed({2'b00, ppt_q})) tick_pos = '0;
    else if (tick_nxt[32]) tick_pos = ppt_q;
    else tick_pos = tick_nxt[30:0];
  end

  // Normalize rounding, x 45 step, quotient rounding
  always_comb begin
    nrm  = rnd_norm(x_q);
    prod = {6'd0, ms_q} * 30'd45;
    if (prod[29]) begin
      mrnd = rne24(prod[29:6], prod[5], |prod[4:0]);
      mexp = es_q + 9'd9 + {8'd0, mrnd.ovf};
    end else begin
      mrnd = rne24(prod[28:5], prod[4], |prod[3:0]);
      mexp = es_q + 9'd8 + {8'd0, mrnd.ovf};
    end
    fq = div_rsp_i.quot[25:0];
    if (fq[25]) begin
      frnd = rne24(fq[25:2], fq[1], fq[0] | div_rsp_i.rem_nz);
      fexp = es_q - ed_q - 9'd23 + {8'd0, frnd.ovf} + 9'd150;
    end else begin
      frnd = rne24(fq[24:1], fq[0], div_rsp_i.rem_nz);
      fexp = es_q - ed_q - 9'd24 + {8'd0, frnd.ovf} + 9'd150;
    end
    q_spd = div_rsp_i.quot[31:0];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_go) begin
          case (head_i.fn)
            FN_SPEED: state_d = ST_DIV_BASE;
            FN_ANGLE: state_d = (ppt_q == '0 || pos_q == '0) ? ST_DONE : ST_NORM_P;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_DIV_BASE: if (div_rsp_i.done) state_d = (pay_q == '0) ? ST_DONE : ST_DIV_Q;
      ST_DIV_Q:    if (div_rsp_i.done) state_d = ST_DONE;
      ST_NORM_P:   if (x_q[30]) state_d = ST_MUL;
      ST_MUL:      state_d = ST_NORM_D;
      ST_NORM_D:   if (x_q[30]) state_d = ST_DIV_F;
      ST_DIV_F:    if (div_rsp_i.done) state_d = ST_DONE;
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Queue pop and divider requests
  always_comb begin
    pop_o     = (state_q == ST_IDLE) && head_i.valid;
    div_req_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_go && head_i.fn == FN_SPEED) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = TIMER_CLK;
          div_req_o.divisor  = {16'd0, prescaler_i} + 32'd1;
        end
      end
      ST_DIV_BASE: begin
        if (div_rsp_i.done && pay_q != '0) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = {17'd0, q_spd};
          div_req_o.divisor  = pay_q;
        end
      end
      ST_NORM_D: begin
        if (x_q[30]) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = {ms_q, 25'd0};
          div_req_o.divisor  = {8'd0, nrm.m};
        end
      end
      default: ;
    endcase
  end

  // Tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      ppt_q       <= RESET_TURN;
      dir_q       <= DIR_STOP;
      en_q        <= 1'b0;
      pin_q       <= 1'b0;
      reload_q    <= '0;
      compare_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Reply slot: load from the done state, clear once taken
      if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (head_i.valid && head_i.tick) pos_q <= tick_pos;
          else if (cmd_go) begin
            case (head_i.fn)
              FN_TURN: ppt_q <= head_i.payload[30:0];
              FN_ZERO: pos_q <= '0;
              FN_FWD: begin
                dir_q <= DIR_FWD;
                pin_q <= 1'b1;
                en_q  <= 1'b1;
              end
              FN_REV: begin
                dir_q <= DIR_REV;
                pin_q <= 1'b0;
                en_q  <= 1'b1;
              end
              FN_STOP: begin
                dir_q <= DIR_STOP;
                en_q  <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_DIV_BASE: begin
          if (div_rsp_i.done && pay_q == '0) begin
            reload_q  <= 32'hFFFFFFFE;
            compare_q <= 32'h7FFFFFFE;
          end
        end
        ST_DIV_Q: begin
          if (div_rsp_i.done) begin
            reload_q  <= q_spd - 32'd1;
            compare_q <= {1'b0, q_spd[31:1]} - 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Work and output payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (cmd_go) begin
          fn_q  <= head_i.fn;
          pay_q <= head_i.payload;
          x_q   <= pos_q;
          sh_q  <= '0;
          if (head_i.fn == FN_ZERO) rep_q <= '0;
          else if (head_i.fn == FN_ANGLE && ppt_q == '0)
            rep_q <= (pos_q == '0) ? ANGLE_NAN : ANGLE_INF;
          else if (head_i.fn == FN_ANGLE && pos_q == '0) rep_q <= '0;
          else rep_q <= head_i.payload;
        end
      end
      ST_NORM_P: begin
        if (x_q[30]) begin
          ms_q <= nrm.m;
          es_q <= 9'd7 - {4'd0, sh_q} + {8'd0, nrm.ovf};
        end else begin
          x_q  <= {x_q[29:0], 1'b0};
          sh_q <= sh_q + 5'd1;
        end
      end
      ST_MUL: begin
        ms_q <= mrnd.m;
        es_q <= mexp;
        x_q  <= ppt_q;
        sh_q <= '0;
      end
      ST_NORM_D: begin
        if (x_q[30]) begin
          ed_q <= 9'd7 - {4'd0, sh_q} + {8'd0, nrm.ovf};
        end else begin
          x_q  <= {x_q[29:0], 1'b0};
          sh_q <= sh_q + 5'd1;
        end
      end
      ST_DIV_F: begin
        if (div_rsp_i.done) rep_q <= {1'b0, fexp[7:0], frnd.m[22:0]};
      end
      ST_DONE: begin
        if (out_free) begin
          o_fn_q  <= fn_q;
          o_pay_q <= rep_q;
          o_dir_q <= pin_q;
          o_run_q <= en_q;
          o_per_q <= reload_q;
          o_cmp_q <= compare_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign reply_function_o  = {4'd0, o_fn_q};
  assign reply_payload_o   = o_pay_q;
  assign direction_level_o = o_dir_q;
  assign pulses_running_o  = o_run_q;
  assign period_value_o    = o_per_q;
  assign compare_value_o   = o_cmp_q;

endmodule

>>> rtl/stepper_command_position_tracker.sv
// Top level of the stepper command position tracker.
// Depends on scpt_pkg, scpt_front, scpt_div and scpt_back.

// Items enter a four-entry command queue, so input transfers continue while
// the back end is busy or a reply waits on the output, until the queue is
// full. The back end handles one queued item at a time. A step tick is
// handled in the idle state and moves the position when the back end pops
// it. A command passes through the idle state, which issues it, and the done
// state, which loads the reply; the done state waits while the previous reply
// still sits unaccepted in the output register. The speed command runs two
// 49-step divisions on the shared divider, only the first with a zero rate.
// The angle command normalizes the position and the turn count one bit per
// cycle, spends one multiply step and one mantissa division; with a zero
// position or turn count it goes straight to the done state. Rejected frames
// and unknown functions are dropped at the queue input and cost no back-end
// time.
module stepper_command_position_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [3:0]  received_bytes_i,
  input  logic [15:0] frame_head_i,
  input  logic [7:0]  function_code_i,
  input  logic [31:0] payload_i,
  input  logic [15:0] frame_tail_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  reply_function_o,
  output logic [31:0] reply_payload_o,
  output logic        direction_level_o,
  output logic        pulses_running_o,
  output logic [31:0] period_value_o,
  output logic [31:0] compare_value_o
);
  import scpt_pkg::*;

  logic [15:0] prescaler_q;
  q_head_t     head;
  logic        pop;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // Timer prescaler register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescaler_q <= '0;
    end else if (cfg_we_i) begin
      prescaler_q <= cfg_wdata_i;
    end
  end

  scpt_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .received_bytes_i (received_bytes_i),
    .frame_head_i     (frame_head_i),
    .function_code_i  (function_code_i),
    .payload_i        (payload_i),
    .frame_tail_i     (frame_tail_i),
    .head_o           (head),
    .pop_i            (pop)
  );

  scpt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  scpt_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .prescaler_i       (prescaler_q),
    .head_i            (head),
    .pop_o             (pop),
    .div_req_o         (div_req),
    .div_rsp_i         (div_rsp),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .reply_function_o  (reply_function_o),
    .reply_payload_o   (reply_payload_o),
    .direction_level_o (direction_level_o),
    .pulses_running_o  (pulses_running_o),
    .period_value_o    (period_value_o),
    .compare_value_o   (compare_value_o)
  );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for stepper_command_position_tracker.
// Depends on scpt_pkg and the rtl; predicts every reply and checks it field by field.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import scpt_pkg::*;

  localparam int CYC_LIMIT = 1000000;
  localparam int SETTLE    = 200;

  typedef struct {
    logic        cmd;
    logic [3:0]  nbytes;
    logic [15:0] head;
    logic [7:0]  fn;
    logic [31:0] payload;
    logic [15:0] tail;
  } item_t;

  typedef struct {
    logic [7:0]  fn;
    logic [31:0] payload;
    logic        dir_pin;
    logic        running;
    logic [31:0] period;
    logic [31:0] compare;
  } reply_t;

  typedef struct {
    logic [23:0] m;
    int          e;
  } flt_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        cmd_i = 1'b0;
  logic [3:0]  received_bytes_i = '0;
  logic [15:0] frame_head_i = '0;
  logic [7:0]  function_code_i = '0;
  logic [31:0] payload_i = '0;
  logic [15:0] frame_tail_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  reply_function_o;
  logic [31:0] reply_payload_o;
  logic        direction_level_o;
  logic        pulses_running_o;
  logic [31:0] period_value_o;
  logic [31:0] compare_value_o;

  // Tracker state as the predictor sees it
  logic [15:0] prescaler;
  logic [30:0] position;
  dir_e        step_dir;
  logic [30:0] turn_count;
  logic        pulse_en;
  logic        dir_pin;
  logic [31:0] reload_reg;
  logic [31:0] compare_reg;

  reply_t pending_replies[$];
  int     errors = 0;
  int     cycles = 0;
  int     stall_pct = 0;
  int     hold_off = 0;
  int     burst_left = 0;
  int     gap_max = 0;

  stepper_command_position_tracker i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .cmd_i, .received_bytes_i, .frame_head_i,
    .function_code_i, .payload_i, .frame_tail_i,
    .out_valid_o, .out_stall_i, .reply_function_o, .reply_payload_o,
    .direction_level_o, .pulses_running_o, .period_value_o, .compare_value_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Round a nonzero v * 2^e to a 24-bit mantissa, nearest even
  function automatic flt_t round24(input logic [63:0] v, input int e);
    flt_t        r;
    int          k;
    int          sh;
    logic [63:0] kept;
    logic        g;
    logic        s;
    k = 63;
    while (k > 0 && !v[k]) k--;
    if (k <= 23) begin
      r.m = 24'(v << (23 - k));
      r.e = e - (23 - k);
    end else begin
      sh = k - 23;
      kept = v >> sh;
      g = v[sh-1];
      s = (sh > 1) ? |(v & ((64'd1 << (sh - 1)) - 64'd1)) : 1'b0;
      kept = kept + 64'(g & (s | kept[0]));
      if (kept[24]) begin
        kept = kept >> 1;
        sh++;
      end
      r.m = kept[23:0];
      r.e = e + sh;
    end
    return r;
  endfunction

  // position * 360 / turn_count in single precision, as IEEE bits
  function automatic logic [31:0] angle_of(input logic [30:0] pos, input logic [30:0] turns);
    flt_t        p;
    flt_t        sc;
    flt_t        d;
    flt_t        q;
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] rem;
    if (turns == 0) return (pos == 0) ? ANGLE_NAN : ANGLE_INF;
    if (pos == 0) return 32'd0;
    p = round24(64'(pos), 0);
    sc = round24(64'(p.m) * 64'd360, p.e);
    d = round24(64'(turns), 0);
    num = 64'(sc.m) << 26;
    quo = num / 64'(d.m);
    rem = num % 64'(d.m);
    q = round24((quo << 1) | 64'(rem != 0), sc.e - d.e - 27);
    return {1'b0, 8'(q.e + 23 + 127), q.m[22:0]};
  endfunction

  // Apply one accepted transfer and queue the reply it causes
  function automatic void track_command(input item_t it);
    reply_t      r;
    logic [31:0] base;
    logic [31:0] quo;
    longint      nxt;
    if (!it.cmd) begin
      nxt = longint'(position);
      if (step_dir == DIR_FWD) nxt++;
      else if (step_dir == DIR_REV) nxt--;
      if (nxt > longint'(turn_count)) position = '0;
      else if (nxt < 0) position = turn_count;
      else position = 31'(nxt);
      return;
    end
    if (it.nbytes < FRAME_MIN || it.head != HEAD_WORD || it.tail != TAIL_WORD ||
        it.fn > 8'(FN_STOP)) return;
    r.payload = it.payload;
    case (it.fn)
      8'(FN_TURN): turn_count = it.payload[30:0];
      8'(FN_SPEED): begin
        base = 32'(TIMER_CLK) / (32'(prescaler) + 32'd1);
        quo = (it.payload == 0) ? 32'hFFFF_FFFF : base / it.payload;
        reload_reg = quo - 32'd1;
        compare_reg = (quo >> 1) - 32'd1;
      end
      8'(FN_ZERO): begin
        position = '0;
        r.payload = '0;
      end
      8'(FN_ANGLE): r.payload = angle_of(position, turn_count);
      8'(FN_FWD): begin
        step_dir = DIR_FWD;
        dir_pin = 1'b1;
        pulse_en = 1'b1;
      end
      8'(FN_REV): begin
        step_dir = DIR_REV;
        dir_pin = 1'b0;
        pulse_en = 1'b1;
      end
      8'(FN_STOP): begin
        step_dir = DIR_STOP;
        pulse_en = 1'b0;
      end
      default: ;
    endcase
    r.fn = it.fn;
    r.dir_pin = dir_pin;
    r.running = pulse_en;
    r.period = reload_reg;
    r.compare = compare_reg;
    pending_replies.push_back(r);
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Receiver stall: long hold-off first, then its own random pattern
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_stall_i <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Reply checker
  always @(posedge clk_i) begin
    reply_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        report("unexpected reply", {24'd0, reply_function_o}, 32'd0);
      end else begin
        w = pending_replies.pop_front();
        if (reply_function_o !== w.fn) report("function", 32'(reply_function_o), 32'(w.fn));
        if (reply_payload_o !== w.payload) report("payload", reply_payload_o, w.payload);
        if (direction_level_o !== w.dir_pin)
          report("direction", 32'(direction_level_o), 32'(w.dir_pin));
        if (pulses_running_o !== w.running)
          report("running", 32'(pulses_running_o), 32'(w.running));
        if (period_value_o !== w.period) report("period", period_value_o, w.period);
        if (compare_value_o !== w.compare) report("compare", compare_value_o, w.compare);
      end
    end
  end

  // One input transfer; valid stays high within a burst
  task automatic send_item(input item_t it);
    @(negedge clk_i);
    cmd_i = it.cmd;
    received_bytes_i = it.nbytes;
    frame_head_i = it.head;
    function_code_i = it.fn;
    payload_i = it.payload;
    frame_tail_i = it.tail;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    track_command(it);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 20);
      if (gap_max > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat ($urandom_range(0, gap_max)) @(negedge clk_i);
      end
    end
  endtask

  function automatic item_t tick();
    item_t it;
    it.cmd = 1'b0;
    it.nbytes = 4'($urandom);
    it.head = 16'($urandom);
    it.fn = 8'($urandom);
    it.payload = $urandom;
    it.tail = 16'($urandom);
    return it;
  endfunction

  function automatic item_t frame(input logic [7:0] fn, input logic [31:0] payload);
    item_t it;
    it.cmd = 1'b1;
    it.nbytes = FRAME_MIN;
    it.head = HEAD_WORD;
    it.fn = fn;
    it.payload = payload;
    it.tail = TAIL_WORD;
    return it;
  endfunction

  // Sender pauses until every reply has come, then lets the back end settle
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_prescaler(input logic [15:0] value);
    drain();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    prescaler = value;
  endtask

  // Wraps, zero turn count, lowered count, speed extremes, rejected frames
  task automatic test_directed();
    item_t it;
    gap_max = 0;
    stall_pct = 0;
    send_item(frame(8'(FN_TURN), 32'd3));
    send_item(frame(8'(FN_FWD), 32'd0));
    repeat (5) send_item(tick());
    send_item(frame(8'(FN_ANGLE), 32'd0));
    send_item(frame(8'(FN_REV), 32'hFFFF_FFFF));
    repeat (2) send_item(tick());
    send_item(frame(8'(FN_ANGLE), 32'd0));
    send_item(frame(8'(FN_TURN), 32'd1));
    send_item(tick());
    send_item(frame(8'(FN_TURN), 32'hFFFF_FFFF));
    send_item(frame(8'(FN_ANGLE), 32'd0));
    send_item(frame(8'(FN_TURN), 32'd0));
    send_item(frame(8'(FN_ANGLE), 32'd0));
    send_item(frame(8'(FN_ZERO), 32'h1234_5678));
    send_item(frame(8'(FN_ANGLE), 32'd0));
    send_item(frame(8'(FN_SPEED), 32'd0));
    send_item(frame(8'(FN_SPEED), 32'd1));
    send_item(frame(8'(FN_SPEED), 32'hFFFF_FFFF));
    send_item(frame(8'(FN_ECHO), 32'hA5A5_5A5A));
    send_item(frame(8'(FN_STATUS), 32'h5A5A_A5A5));
    send_item(frame(8'(FN_STOP), 32'd0));
    it = frame(8'(FN_ECHO), 32'd1);
    it.nbytes = 4'd8;
    send_item(it);
    it.nbytes = 4'd15;
    it.head = 16'hFEEE;
    send_item(it);
    it.head = HEAD_WORD;
    it.tail = 16'hEEFE;
    send_item(it);
    send_item(frame(8'd9, 32'd0));
    send_item(frame(8'd255, 32'd0));
    it = frame(8'(FN_ECHO), 32'd7);
    it.nbytes = 4'd15;
    send_item(it);
  endtask

  // Receiver holds off while the sender keeps sending echo frames
  task automatic test_backpressure();
    int n;
    drain();
    gap_max = 0;
    hold_off = 600;
    for (n = 0; n < 16; n++) send_item(frame(8'(FN_ECHO), $urandom));
    drain();
  endtask

  function automatic item_t random_item();
    item_t it;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 45) return tick();
    if (pick < 88) begin
      it = frame(8'($urandom_range(0, 8)), $urandom);
      if (it.fn == 8'(FN_TURN) && $urandom_range(3) != 0) it.payload = $urandom_range(0, 40);
      if (it.fn == 8'(FN_SPEED) && $urandom_range(1) != 0) it.payload = $urandom_range(0, 5000);
      if ($urandom_range(3) == 0) it.nbytes = 4'($urandom_range(9, 15));
      return it;
    end
    it = tick();
    it.cmd = 1'b1;
    if (pick < 94) begin
      it.head = HEAD_WORD;
      it.tail = TAIL_WORD;
      case ($urandom_range(3))
        0: it.nbytes = 4'($urandom_range(0, 8));
        1: it.head = 16'($urandom);
        2: it.tail = 16'($urandom);
        default: it.fn = 8'($urandom_range(9, 255));
      endcase
    end
    return it;
  endfunction

  task automatic test_random(input int count, input int gaps, input int stalls);
    int n;
    gap_max = gaps;
    stall_pct = stalls;
    for (n = 0; n < count; n++) send_item(random_item());
  endtask

  initial begin
    prescaler = '0;
    position = '0;
    step_dir = DIR_STOP;
    turn_count = RESET_TURN;
    pulse_en = 1'b0;
    dir_pin = 1'b0;
    reload_reg = '0;
    compare_reg = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    write_prescaler(16'd0);
    test_directed();
    test_backpressure();
    test_random(400, 0, 0);
    write_prescaler(16'hFFFF);
    test_random(400, 6, 30);
    write_prescaler(16'($urandom));
    test_random(450, 3, 70);
    write_prescaler(16'd83);
    test_random(400, 10, 10);
    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
